[rtl/gla_pkg.sv]
// Shared widths, event codes and word types for the gang lock arbiter.
package gla_pkg;

  localparam int CORE_W        = 3;
  localparam int TASK_W        = 22;
  localparam int GANG_W        = 22;
  localparam int PRIO_W        = 7;
  localparam int DL_W          = 64;
  localparam int MASK_OUT_W    = 8;
  localparam int EV_W          = 3;
  localparam int NUM_CORES_DEF = 8;

  localparam logic [EV_W-1:0] EV_START   = 3'd0;
  localparam logic [EV_W-1:0] EV_JOIN    = 3'd1;
  localparam logic [EV_W-1:0] EV_PREEMPT = 3'd2;
  localparam logic [EV_W-1:0] EV_BLOCK   = 3'd3;
  localparam logic [EV_W-1:0] EV_PART    = 3'd4;
  localparam logic [EV_W-1:0] EV_FREED   = 3'd5;
  localparam logic [EV_W-1:0] EV_IGNORED = 3'd6;

  localparam logic REQ_ACQUIRE = 1'b0;

  typedef struct packed {
    logic              req_type;
    logic [CORE_W-1:0] core;
    logic [TASK_W-1:0] task_id;
    logic [GANG_W-1:0] gang_id;
    logic              is_deadline_class;
    logic [PRIO_W-1:0] priority_req;
    logic [DL_W-1:0]   deadline;
  } req_t;

  typedef struct packed {
    logic                  verdict;
    logic [MASK_OUT_W-1:0] resched_mask;
    logic [EV_W-1:0]       event_res;
  } res_t;

endpackage

[rtl/gla_core.sv]
// Lock state, holder table and per-request decision logic.
module gla_core #(
  parameter int NUM_CORES = gla_pkg::NUM_CORES_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          advance,
  input  gla_pkg::req_t req,
  output gla_pkg::res_t res
);

  // only cores addressable by the core field get storage
  localparam int ADDR_N = 1 << gla_pkg::CORE_W;
  localparam int MASK_N = (NUM_CORES < ADDR_N) ? NUM_CORES : ADDR_N;
  localparam int IDX_W  = (MASK_N > 1) ? $clog2(MASK_N) : 1;
  localparam logic [gla_pkg::CORE_W:0] CORE_LIMIT = (gla_pkg::CORE_W + 1)'(MASK_N);

  logic                        lock_busy, lock_busy_next;
  logic [MASK_N-1:0]           locked_mask, locked_mask_next;
  logic [MASK_N-1:0]           blocked_mask, blocked_mask_next;
  logic [gla_pkg::TASK_W-1:0]  holder_task [MASK_N];
  logic [gla_pkg::GANG_W-1:0]  leader_gang, leader_gang_next;
  logic                        leader_is_deadline, leader_is_deadline_next;
  logic [gla_pkg::PRIO_W-1:0]  leader_priority, leader_priority_next;
  logic [gla_pkg::DL_W-1:0]    leader_deadline, leader_deadline_next;

  logic                        in_range;
  logic [MASK_N-1:0]           bit_sel;
  logic [IDX_W-1:0]            idx;
  logic [gla_pkg::DL_W-1:0]    dl_diff;
  logic                        preempt;
  logic [MASK_N-1:0]           hit;
  logic [MASK_N-1:0]           remain;
  logic                        holder_we;

  assign in_range = {1'b0, req.core} < CORE_LIMIT;
  assign bit_sel  = MASK_N'(1) << req.core;
  assign idx      = IDX_W'(req.core);
  assign dl_diff  = req.deadline - leader_deadline;

  always_comb begin
    if (req.is_deadline_class != leader_is_deadline) begin
      preempt = req.is_deadline_class;
    end else if (req.is_deadline_class) begin
      preempt = dl_diff[gla_pkg::DL_W-1];
    end else begin
      preempt = req.priority_req < leader_priority;
    end
  end

  always_comb begin
    for (int i = 0; i < MASK_N; i++) begin
      hit[i] = locked_mask[i] && (holder_task[i] == req.task_id);
    end
  end

  assign remain = locked_mask & ~hit;

  always_comb begin
    lock_busy_next          = lock_busy;
    locked_mask_next        = locked_mask;
    blocked_mask_next       = blocked_mask;
    leader_gang_next        = leader_gang;
    leader_is_deadline_next = leader_is_deadline;
    leader_priority_next    = leader_priority;
    leader_deadline_next    = leader_deadline;
    holder_we               = 1'b0;
    res.verdict             = 1'b0;
    res.resched_mask        = '0;
    res.event_res           = gla_pkg::EV_IGNORED;
    if (in_range) begin
      if (req.req_type == gla_pkg::REQ_ACQUIRE) begin
        priority if (!lock_busy) begin
          lock_busy_next          = 1'b1;
          locked_mask_next        = bit_sel;
          holder_we               = 1'b1;
          leader_gang_next        = req.gang_id;
          leader_is_deadline_next = req.is_deadline_class;
          leader_priority_next    = req.priority_req;
          leader_deadline_next    = req.deadline;
          res.event_res           = gla_pkg::EV_START;
        end else if (req.gang_id == leader_gang) begin
          locked_mask_next = locked_mask | bit_sel;
          holder_we        = 1'b1;
          res.event_res    = gla_pkg::EV_JOIN;
        end else if (preempt) begin
          locked_mask_next        = bit_sel;
          holder_we               = 1'b1;
          leader_gang_next        = req.gang_id;
          leader_is_deadline_next = req.is_deadline_class;
          leader_priority_next    = req.priority_req;
          leader_deadline_next    = req.deadline;
          res.resched_mask        = gla_pkg::MASK_OUT_W'(locked_mask & ~bit_sel);
          res.event_res           = gla_pkg::EV_PREEMPT;
        end else begin
          blocked_mask_next = blocked_mask | bit_sel;
          res.verdict       = 1'b1;
          res.event_res     = gla_pkg::EV_BLOCK;
        end
      end else if (lock_busy) begin
        if (remain == '0) begin
          lock_busy_next          = 1'b0;
          locked_mask_next        = '0;
          blocked_mask_next       = '0;
          leader_gang_next        = '0;
          leader_is_deadline_next = 1'b0;
          leader_priority_next    = '0;
          leader_deadline_next    = '0;
          res.resched_mask        = gla_pkg::MASK_OUT_W'(blocked_mask & ~bit_sel);
          res.event_res           = gla_pkg::EV_FREED;
        end else begin
          locked_mask_next = remain;
          res.event_res    = gla_pkg::EV_PART;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lock_busy          <= 1'b0;
      locked_mask        <= '0;
      blocked_mask       <= '0;
      leader_gang        <= '0;
      leader_is_deadline <= 1'b0;
      leader_priority    <= '0;
      leader_deadline    <= '0;
    end else if (advance) begin
      lock_busy          <= lock_busy_next;
      locked_mask        <= locked_mask_next;
      blocked_mask       <= blocked_mask_next;
      leader_gang        <= leader_gang_next;
      leader_is_deadline <= leader_is_deadline_next;
      leader_priority    <= leader_priority_next;
      leader_deadline    <= leader_deadline_next;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && holder_we) begin
      holder_task[idx] <= req.task_id;
    end
  end

  a_busy_locked: assert property (@(posedge clk) disable iff (rst)
    lock_busy == (locked_mask != '0))
    else $error("lock_busy disagrees with locked_mask");

  a_blocked_busy: assert property (@(posedge clk) disable iff (rst)
    (blocked_mask != '0) |-> lock_busy)
    else $error("blocked cores while lock is free");

  a_free_leader: assert property (@(posedge clk) disable iff (rst)
    !lock_busy |-> (leader_gang == '0 && leader_priority == '0 && !leader_is_deadline))
    else $error("leader fields not cleared while lock is free");

  a_preempt_single: assert property (@(posedge clk) disable iff (rst)
    (advance && res.event_res == gla_pkg::EV_PREEMPT) |=> $onehot(locked_mask))
    else $error("preempt left more than one core locked");

endmodule

[rtl/gang_lock_arbiter_top.sv]
// Gang lock arbiter top level: request register, decision core, result register.
// One request word is decided per clock while the result side is not stalled: a word
// taken into the request register is resolved against the lock state once the result
// register is empty or being read, and its result lands in the result register, so
// throughput is one word per cycle when out_ready holds. A new word is accepted while the
// result waits, as long as the request register is empty or moving on. Cores at or
// above NUM_CORES are ignored.
module gang_lock_arbiter_top #(
  parameter int NUM_CORES = gla_pkg::NUM_CORES_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            req_type,
  input  logic [gla_pkg::CORE_W-1:0]      core,
  input  logic [gla_pkg::TASK_W-1:0]      task_id,
  input  logic [gla_pkg::GANG_W-1:0]      gang_id,
  input  logic                            is_deadline_class,
  input  logic [gla_pkg::PRIO_W-1:0]      priority_req,
  input  logic [gla_pkg::DL_W-1:0]        deadline,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            verdict,
  output logic [gla_pkg::MASK_OUT_W-1:0]  resched_mask,
  output logic [gla_pkg::EV_W-1:0]        event_res
);

  gla_pkg::req_t req_q;
  logic          req_vld;
  gla_pkg::res_t res_c;
  gla_pkg::res_t res_q;
  logic          advance;

  assign advance  = req_vld && (!out_valid || out_ready);
  assign in_ready = !req_vld || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      req_vld   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        req_vld <= 1'b1;
      end else if (advance) begin
        req_vld <= 1'b0;
      end
      if (advance) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req_q.req_type          <= req_type;
      req_q.core              <= core;
      req_q.task_id           <= task_id;
      req_q.gang_id           <= gang_id;
      req_q.is_deadline_class <= is_deadline_class;
      req_q.priority_req      <= priority_req;
      req_q.deadline          <= deadline;
    end
    if (advance) begin
      res_q <= res_c;
    end
  end

  gla_core #(
    .NUM_CORES(NUM_CORES)
  ) u_core (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .req     (req_q),
    .res     (res_c)
  );

  assign verdict      = res_q.verdict;
  assign resched_mask = res_q.resched_mask;
  assign event_res    = res_q.event_res;

endmodule

[bench/testbench.sv]
// Self-checking testbench for gang_lock_arbiter_top: directed and random request words.
module testbench;

  localparam int NCORES = gla_pkg::NUM_CORES_DEF;
  localparam logic REQ_RELEASE = ~gla_pkg::REQ_ACQUIRE;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned SEG_WORDS = 175;

  class lock_scoreboard;
    gla_pkg::res_t verdicts_due[$];
    int unsigned failures;
    bit held;
    logic [NCORES-1:0] busy_cores;
    logic [NCORES-1:0] parked_cores;
    logic [gla_pkg::TASK_W-1:0] holder[NCORES];
    logic [gla_pkg::GANG_W-1:0] lead_gang;
    logic lead_dl;
    logic [gla_pkg::PRIO_W-1:0] lead_prio;
    logic [gla_pkg::DL_W-1:0] lead_dead;

    function void clear_lock();
      held = 1'b0;
      busy_cores = '0;
      parked_cores = '0;
      lead_gang = '0;
      lead_dl = 1'b0;
      lead_prio = '0;
      lead_dead = '0;
    endfunction

    function void take_lead(gla_pkg::req_t w);
      lead_gang = w.gang_id;
      lead_dl = w.is_deadline_class;
      lead_prio = w.priority_req;
      lead_dead = w.deadline;
    endfunction

    function bit core_locked(logic [gla_pkg::CORE_W-1:0] c);
      return held && busy_cores[c];
    endfunction

    // lock decision for one word; updates the shadow lock state
    function gla_pkg::res_t arbitrate(gla_pkg::req_t w);
      gla_pkg::res_t r;
      logic [NCORES-1:0] bit_c;
      logic [gla_pkg::DL_W-1:0] diff;
      bit wins;
      int i;
      r.verdict = 1'b0;
      r.resched_mask = '0;
      r.event_res = gla_pkg::EV_IGNORED;
      if (int'(w.core) >= NCORES) return r;
      bit_c = '0;
      bit_c[w.core] = 1'b1;
      if (w.req_type == gla_pkg::REQ_ACQUIRE) begin
        if (!held) begin
          held = 1'b1;
          busy_cores = bit_c;
          holder[w.core] = w.task_id;
          take_lead(w);
          r.event_res = gla_pkg::EV_START;
        end else if (w.gang_id == lead_gang) begin
          busy_cores |= bit_c;
          holder[w.core] = w.task_id;
          r.event_res = gla_pkg::EV_JOIN;
        end else begin
          diff = w.deadline - lead_dead;
          if (w.is_deadline_class != lead_dl) wins = w.is_deadline_class;
          else if (w.is_deadline_class) wins = diff[gla_pkg::DL_W-1];
          else wins = w.priority_req < lead_prio;
          if (wins) begin
            r.resched_mask = busy_cores & ~bit_c;
            busy_cores = bit_c;
            holder[w.core] = w.task_id;
            take_lead(w);
            r.event_res = gla_pkg::EV_PREEMPT;
          end else begin
            parked_cores |= bit_c;
            r.verdict = 1'b1;
            r.event_res = gla_pkg::EV_BLOCK;
          end
        end
      end else if (held) begin
        for (i = 0; i < NCORES; i++) begin
          if (busy_cores[i] && holder[i] == w.task_id) busy_cores[i] = 1'b0;
        end
        if (busy_cores == '0) begin
          r.resched_mask = parked_cores & ~bit_c;
          clear_lock();
          r.event_res = gla_pkg::EV_FREED;
        end else begin
          r.event_res = gla_pkg::EV_PART;
        end
      end
      return r;
    endfunction

    function void note_request(gla_pkg::req_t w);
      verdicts_due.push_back(arbitrate(w));
    endfunction

    function void check_result(logic v, logic [gla_pkg::MASK_OUT_W-1:0] m,
                               logic [gla_pkg::EV_W-1:0] e);
      gla_pkg::res_t want;
      if (verdicts_due.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("result with nothing pending: verdict %0d mask %h event %0d", v, m, e);
        return;
      end
      want = verdicts_due.pop_front();
      if (v !== want.verdict || m !== want.resched_mask || e !== want.event_res) begin
        failures++;
        if (failures <= 10)
          $display("mismatch: verdict %0d/%0d mask %h/%h event %0d/%0d (expected/actual)",
                   want.verdict, v, want.resched_mask, m, want.event_res, e);
      end
    endfunction

    function int pending();
      return verdicts_due.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  logic in_valid;
  logic in_ready;
  logic req_type;
  logic [gla_pkg::CORE_W-1:0] core;
  logic [gla_pkg::TASK_W-1:0] task_id;
  logic [gla_pkg::GANG_W-1:0] gang_id;
  logic is_deadline_class;
  logic [gla_pkg::PRIO_W-1:0] priority_req;
  logic [gla_pkg::DL_W-1:0] deadline;
  logic out_valid;
  logic out_ready;
  logic verdict;
  logic [gla_pkg::MASK_OUT_W-1:0] resched_mask;
  logic [gla_pkg::EV_W-1:0] event_res;

  lock_scoreboard board;
  int unsigned cycles;
  int unsigned gap_odds;
  int unsigned stall_odds;
  int unsigned hold_cnt;

  gang_lock_arbiter_top uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .req_type(req_type), .core(core), .task_id(task_id), .gang_id(gang_id),
    .is_deadline_class(is_deadline_class), .priority_req(priority_req),
    .deadline(deadline),
    .out_valid(out_valid), .out_ready(out_ready),
    .verdict(verdict), .resched_mask(resched_mask), .event_res(event_res)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("** gang_lock_arbiter_top: FAILED **");
      $finish;
    end
  end

  // result side: check accepted words, stall in short random bursts
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) board.check_result(verdict, resched_mask, event_res);
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_ready <= 1'b0;
    end else if (stall_odds != 0 && $urandom_range(0, stall_odds) == 0) begin
      hold_cnt = $urandom_range(1, 5) - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  function gla_pkg::req_t mk(logic t, logic [gla_pkg::CORE_W-1:0] c,
                             logic [gla_pkg::TASK_W-1:0] tk,
                             logic [gla_pkg::GANG_W-1:0] g, logic dl,
                             logic [gla_pkg::PRIO_W-1:0] p,
                             logic [gla_pkg::DL_W-1:0] d);
    gla_pkg::req_t w;
    w.req_type = t;
    w.core = c;
    w.task_id = tk;
    w.gang_id = g;
    w.is_deadline_class = dl;
    w.priority_req = p;
    w.deadline = d;
    return w;
  endfunction

  // small task and gang pools so joins, holder releases and frees are common
  function gla_pkg::req_t random_word();
    gla_pkg::req_t w;
    int unsigned pick;
    w.req_type = ($urandom_range(0, 99) < 40) ? REQ_RELEASE : gla_pkg::REQ_ACQUIRE;
    w.core = gla_pkg::CORE_W'($urandom_range(0, NCORES - 1));
    pick = $urandom_range(0, 9);
    if (w.req_type == REQ_RELEASE && pick < 6 && board.core_locked(w.core))
      w.task_id = board.holder[w.core];
    else if (pick < 8) w.task_id = gla_pkg::TASK_W'(16 + $urandom_range(0, 5));
    else w.task_id = gla_pkg::TASK_W'($urandom_range(0, 22'h3FFFFF));
    if ($urandom_range(0, 4) != 0) w.gang_id = gla_pkg::GANG_W'($urandom_range(0, 3));
    else w.gang_id = gla_pkg::GANG_W'($urandom_range(0, 22'h3FFFFF));
    w.is_deadline_class = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 5))
      0: w.priority_req = 7'd0;
      1: w.priority_req = 7'd99;
      default: w.priority_req = gla_pkg::PRIO_W'($urandom_range(0, 99));
    endcase
    case ($urandom_range(0, 4))
      0: w.deadline = {$urandom, $urandom};
      1: w.deadline = board.lead_dead + 64'($urandom_range(0, 20)) - 64'd10;
      2: w.deadline = board.lead_dead + 64'h8000_0000_0000_0000
                      + 64'($urandom_range(0, 4)) - 64'd2;
      3: w.deadline = $urandom_range(0, 1) ? '1 : '0;
      default: w.deadline = board.lead_dead + 64'($urandom_range(0, 1000)) - 64'd500;
    endcase
    return w;
  endfunction

  task automatic send_word(gla_pkg::req_t w);
    in_valid <= 1'b1;
    req_type <= w.req_type;
    core <= w.core;
    task_id <= w.task_id;
    gang_id <= w.gang_id;
    is_deadline_class <= w.is_deadline_class;
    priority_req <= w.priority_req;
    deadline <= w.deadline;
    do @(posedge clk); while (!in_ready);
    board.note_request(w);
  endtask

  task automatic idle_sender(int unsigned n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (board.pending() != 0);
  endtask

  initial begin
    int seg;
    int n;
    board = new;
    board.clear_lock();
    cycles = 0;
    gap_odds = 0;
    stall_odds = 0;
    hold_cnt = 0;
    rst <= 1'b1;
    in_valid <= 1'b0;
    req_type <= gla_pkg::REQ_ACQUIRE;
    core <= '0;
    task_id <= '0;
    gang_id <= '0;
    is_deadline_class <= 1'b0;
    priority_req <= '0;
    deadline <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    gap_odds = 3;
    stall_odds = 3;
    send_word(mk(REQ_RELEASE, 3'd0, 22'h11, 22'h1, 1'b0, 7'd5, 64'd0));
    send_word(mk(gla_pkg::REQ_ACQUIRE, 3'd0, 22'h11, 22'h1, 1'b0, 7'd50, 64'd0));
    send_word(mk(gla_pkg::REQ_ACQUIRE, 3'd1, 22'h12, 22'h1, 1'b0, 7'd90, 64'd0));
    send_word(mk(gla_pkg::REQ_ACQUIRE, 3'd2, 22'h21, 22'h2, 1'b0, 7'd60, 64'd0));
    idle_sender(2);
    send_word(mk(gla_pkg::REQ_ACQUIRE, 3'd2, 22'h21, 22'h2, 1'b0, 7'd60, 64'd0));
    send_word(mk(gla_pkg::REQ_ACQUIRE, 3'd3, 22'h22, 22'h2, 1'b0, 7'd50, 64'd0));
    send_word(mk(gla_pkg::REQ_ACQUIRE, 3'd4, 22'h31, 22'h3, 1'b0, 7'd10, 64'd0));
    send_word(mk(gla_pkg::REQ_ACQUIRE, 3'd5, 22'h31, 22'h3, 1'b0, 7'd99, 64'd0));
    send_word(mk(REQ_RELEASE, 3'd6, 22'h77, 22'h3, 1'b0, 7'd0, 64'd0));
    send_word(mk(gla_pkg::REQ_ACQUIRE, 3'd6, 22'h41, 22'h4, 1'b1, 7'd99, 64'd100));
    send_word(mk(gla_pkg::REQ_ACQUIRE, 3'd7, 22'h51, 22'h5, 1'b0, 7'd0, 64'd0));
    send_word(mk(gla_pkg::REQ_ACQUIRE, 3'd0, 22'h61, 22'h6, 1'b1, 7'd0, 64'd99));
    send_word(mk(gla_pkg::REQ_ACQUIRE, 3'd1, 22'h71, 22'h7, 1'b1, 7'd0, 64'd99));
    // half-range distances: wrap-safe compare
    send_word(mk(gla_pkg::REQ_ACQUIRE, 3'd2, 22'h81, 22'h8, 1'b1, 7'd0,
                 64'h8000_0000_0000_0063));
    send_word(mk(gla_pkg::REQ_ACQUIRE, 3'd3, 22'h91, 22'h9, 1'b1, 7'd0,
                 64'h0000_0000_0000_0062));
    send_word(mk(gla_pkg::REQ_ACQUIRE, 3'd4, 22'h92, 22'h9, 1'b1, 7'd0,
                 64'h8000_0000_0000_0062));
    send_word(mk(REQ_RELEASE, 3'd5, 22'h31, 22'h0, 1'b0, 7'd0, 64'd0));
    send_word(mk(REQ_RELEASE, 3'd4, 22'h92, 22'h0, 1'b0, 7'd0, 64'd0));
    send_word(mk(gla_pkg::REQ_ACQUIRE, 3'd7, 22'h3FFFFF, 22'h3FFFFF, 1'b1, 7'd99, '1));
    send_word(mk(gla_pkg::REQ_ACQUIRE, 3'd0, 22'h0, 22'h0, 1'b0, 7'd0, 64'd0));
    send_word(mk(gla_pkg::REQ_ACQUIRE, 3'd6, 22'h3FFFFF, 22'h3FFFFF, 1'b0, 7'd0, 64'd0));
    send_word(mk(REQ_RELEASE, 3'd3, 22'h3FFFFF, 22'h0, 1'b1, 7'd99, '1));
    wait_drained();

    for (seg = 0; seg < 4; seg++) begin
      case (seg)
        0: begin gap_odds = 6; stall_odds = 6; end
        1: begin gap_odds = 0; stall_odds = 0; end
        2: begin gap_odds = 2; stall_odds = 2; end
        default: begin gap_odds = 0; stall_odds = 0; end
      endcase
      for (n = 0; n < SEG_WORDS; n++) begin
        if (gap_odds != 0 && $urandom_range(0, gap_odds) == 0)
          idle_sender($urandom_range(1, 5));
        send_word(random_word());
      end
      if (seg == 1) wait_drained();
    end

    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
    if (board.failures == 0 && board.pending() == 0) begin
      $display("** gang_lock_arbiter_top: PASSED **");
    end else begin
      $display("** gang_lock_arbiter_top: FAILED **");
    end
    $finish;
  end
endmodule
